/* rtl/core/rhbb_pkg.sv */
// shared types and constants for the rudder heading bang-bang controller
// no dependencies

package rhbb_pkg;

	// configuration register indexes
	localparam logic [3:0] REG_TRIM     = 4'd0;
	localparam logic [3:0] REG_INVERT   = 4'd1;
	localparam logic [3:0] REG_MANUAL   = 4'd2;
	localparam logic [3:0] REG_REF      = 4'd3;
	localparam logic [3:0] REG_GAIN     = 4'd4;
	localparam logic [3:0] REG_DEADBAND = 4'd5;
	localparam logic [3:0] REG_FULL     = 4'd6;
	localparam logic [3:0] REG_SLOW     = 4'd7;

	// joystick codes
	localparam logic signed [1:0] JOY_LEFT     = 2'sb11;
	localparam logic signed [1:0] JOY_STRAIGHT = 2'sb00;
	localparam logic signed [1:0] JOY_RIGHT    = 2'sb01;

	// rudder target limits in degrees
	localparam logic [8:0] TARGET_MIN    = 9'd90;
	localparam logic [8:0] TARGET_CENTER = 9'd180;
	localparam logic [8:0] TARGET_MAX    = 9'd270;

	// configuration register file contents
	typedef struct packed {
		logic signed [8:0] trim_tenths;
		logic              invert_rudder;
		logic              manual_mode;
		logic              referenced;
		logic [7:0]        gain_hundredths;
		logic [6:0]        deadband_degrees;
		logic [7:0]        drive_full;
		logic [7:0]        drive_slow;
	} cfg_t;

	// first pipeline stage contents
	typedef struct packed {
		logic              auto_mode;
		logic [8:0]        fixed_target;
		logic signed [23:0] num;
		logic signed [10:0] angle;
		logic signed [1:0]  joystick;
	} stage1_t;

endpackage

/* rtl/core/rhbb_cfg_regs.sv */
// configuration register file for the rudder controller
// depends on rhbb_pkg

module rhbb_cfg_regs
	import rhbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       we,
	input  logic [3:0] index,
	input  logic [8:0] wdata,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trim_tenths      <= 9'sd0;
			cfg_q.invert_rudder    <= 1'b0;
			cfg_q.manual_mode      <= 1'b0;
			cfg_q.referenced       <= 1'b0;
			cfg_q.gain_hundredths  <= 8'd40;
			cfg_q.deadband_degrees <= 7'd10;
			cfg_q.drive_full       <= 8'd255;
			cfg_q.drive_slow       <= 8'd80;
		end else if (we) begin
			unique case (index)
				REG_TRIM:     cfg_q.trim_tenths      <= $signed(wdata);
				REG_INVERT:   cfg_q.invert_rudder    <= wdata[0];
				REG_MANUAL:   cfg_q.manual_mode      <= wdata[0];
				REG_REF:      cfg_q.referenced       <= wdata[0];
				REG_GAIN:     cfg_q.gain_hundredths  <= wdata[7:0];
				REG_DEADBAND: cfg_q.deadband_degrees <= wdata[6:0];
				REG_FULL:     cfg_q.drive_full       <= wdata[7:0];
				REG_SLOW:     cfg_q.drive_slow       <= wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/rhbb_heading_stage.sv */
// first stage logic: heading error, gain product and fixed mode targets
// depends on rhbb_pkg

module rhbb_heading_stage
	import rhbb_pkg::*;
(
	input  logic signed [10:0] rudder_angle,
	input  logic signed [1:0]  joystick,
	input  logic [11:0]        bearing_tenths,
	input  logic [11:0]        course_tenths,
	input  logic               motor_running,
	input  logic               course_valid,
	input  cfg_t               cfg,
	output stage1_t            st
);

	logic [8:0]         trim_mag;
	logic [16:0]        trim_recip;
	logic [4:0]         trim_q;
	logic signed [5:0]  trim_deg;
	logic [8:0]         base;
	logic signed [9:0]  fixed_sum;
	logic signed [12:0] err_raw;
	logic signed [12:0] err_wrap;
	logic signed [13:0] err_trim;
	logic signed [13:0] err_sgn;
	logic signed [8:0]  gain_s;
	logic signed [22:0] prod;

	// trim in whole degrees, truncated toward zero (x*205 >> 11 is exact here)
	always_comb begin
		trim_mag   = cfg.trim_tenths[8] ? 9'(-cfg.trim_tenths) : cfg.trim_tenths;
		trim_recip = 17'(trim_mag) * 17'd205;
		trim_q     = trim_recip[15:11];
		trim_deg   = cfg.trim_tenths[8] ? -$signed({1'b0, trim_q}) : $signed({1'b0, trim_q});
	end

	// manual and idle base angle
	always_comb begin
		if (cfg.manual_mode) begin
			case (joystick)
				JOY_STRAIGHT: base = TARGET_CENTER;
				JOY_RIGHT:    base = cfg.invert_rudder ? TARGET_MIN : TARGET_MAX;
				default:      base = cfg.invert_rudder ? TARGET_MAX : TARGET_MIN;
			endcase
		end else begin
			base = TARGET_CENTER;
		end
		fixed_sum = $signed({1'b0, base}) + 10'(trim_deg);
	end

	// wrapped heading error times gain
	always_comb begin
		err_raw = $signed({1'b0, bearing_tenths}) - $signed({1'b0, course_tenths});
		if (err_raw > 13'sd1800)
			err_wrap = err_raw - 13'sd3600;
		else if (err_raw < -13'sd1800)
			err_wrap = err_raw + 13'sd3600;
		else
			err_wrap = err_raw;
		err_trim = 14'(err_wrap) + 14'(cfg.trim_tenths);
		err_sgn  = cfg.invert_rudder ? -err_trim : err_trim;
		gain_s   = $signed({1'b0, cfg.gain_hundredths});
		prod     = err_sgn * gain_s;
	end

	// stage contents
	always_comb begin
		st.auto_mode = !cfg.manual_mode && motor_running && course_valid;
		if (fixed_sum < 10'sd90)
			st.fixed_target = TARGET_MIN;
		else if (fixed_sum > 10'sd270)
			st.fixed_target = TARGET_MAX;
		else
			st.fixed_target = fixed_sum[8:0];
		st.num      = 24'sd180000 + 24'(prod);
		st.angle    = rudder_angle;
		st.joystick = joystick;
	end

endmodule

/* rtl/core/rhbb_drive_stage.sv */
// second stage logic: scale to degrees, clamp, and bang-bang drive decision
// depends on rhbb_pkg

module rhbb_drive_stage
	import rhbb_pkg::*;
(
	input  stage1_t    st,
	input  cfg_t       cfg,
	output logic [8:0] rudder_target,
	output logic [7:0] drive_speed,
	output logic       drive_up
);

	logic [23:0]        num_off;
	logic [14:0]        num_div8;
	logic [30:0]        recip;
	logic [8:0]         target;
	logic signed [11:0] diff;
	logic [11:0]        diff_abs;
	logic [7:0]         speed;
	logic               up;

	// floor(num / 1000): offset by 90000, then /8 and /125 by reciprocal
	always_comb begin
		num_off  = 24'(st.num - 24'sd90000);
		num_div8 = num_off[17:3];
		recip    = 31'(num_div8) * 31'd33555;
		if (!st.auto_mode)
			target = st.fixed_target;
		else if (st.num < 24'sd90000)
			target = TARGET_MIN;
		else if (st.num > 24'sd270000)
			target = TARGET_MAX;
		else
			target = TARGET_MIN + {1'b0, recip[29:22]};
	end

	// drive toward target with deadband and end stops; before referencing, the joystick jogs at slow speed
	always_comb begin
		diff     = 12'(st.angle) - $signed({3'b000, target});
		diff_abs = diff[11] ? 12'(-diff) : 12'(diff);
		if (!cfg.referenced) begin
			if (st.joystick == JOY_LEFT) begin
				speed = cfg.drive_slow;
				up    = 1'b0;
			end else if (st.joystick == JOY_RIGHT) begin
				speed = cfg.drive_slow;
				up    = 1'b1;
			end else begin
				speed = 8'd0;
				up    = 1'b0;
			end
		end else begin
			up    = !(diff > 12'sd0);
			speed = cfg.drive_full;
			if (st.angle <= 11'sd0 || st.angle >= 11'sd360)
				speed = 8'd0;
			if (diff_abs <= {5'b00000, cfg.deadband_degrees})
				speed = 8'd0;
		end
		rudder_target = target;
		drive_speed   = speed;
		drive_up      = (speed == 8'd0) ? 1'b0 : up;
	end

endmodule

/* rtl/core/rudder_heading_bang_bang_control_top.sv */
// rudder heading bang-bang controller, top level
// a beat accepted on the slave side is registered in stage one and then in stage two before it reaches the master side
// throughput: one beat per cycle while m_tready is high; the gain multiply and the degree scaling sit in
// separate stages, and stage one can still take a beat while stage two waits on m_tready
// reset: pipeline valids cleared, configuration returns to its defaults
// depends on rhbb_pkg, rhbb_cfg_regs, rhbb_heading_stage, rhbb_drive_stage

module rudder_heading_bang_bang_control_top
	import rhbb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	// rudder_angle[10:0], joystick[12:11], bearing_tenths[24:13],
	// course_tenths[36:25], motor_running[37], course_valid[38], zero[39]
	input  logic [39:0] s_tdata,
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	// rudder_target[8:0], drive_speed[16:9], drive_up[17], zero[23:18]
	output logic [23:0] m_tdata,
	// configuration write port
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [8:0]  cfg_wdata
);

	cfg_t       cfg;
	stage1_t    st_comb;
	stage1_t    st_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       adv2;
	logic       load1;
	logic [8:0] target_comb;
	logic [7:0] speed_comb;
	logic       up_comb;
	logic [8:0] target_s2;
	logic [7:0] speed_s2;
	logic       up_s2;

	rhbb_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	rhbb_heading_stage u_heading (
		.rudder_angle   ($signed(s_tdata[10:0])),
		.joystick       ($signed(s_tdata[12:11])),
		.bearing_tenths (s_tdata[24:13]),
		.course_tenths  (s_tdata[36:25]),
		.motor_running  (s_tdata[37]),
		.course_valid   (s_tdata[38]),
		.cfg            (cfg),
		.st             (st_comb)
	);

	rhbb_drive_stage u_drive (
		.st            (st_s1),
		.cfg           (cfg),
		.rudder_target (target_comb),
		.drive_speed   (speed_comb),
		.drive_up      (up_comb)
	);

	// pipeline flow control
	assign adv2     = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv2;
	assign load1    = s_tvalid && s_tready;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load1)
			st_s1 <= st_comb;
		if (adv2 && valid_s1) begin
			target_s2 <= target_comb;
			speed_s2  <= speed_comb;
			up_s2     <= up_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b000000, up_s2, speed_s2, target_s2};

	// target always within the rudder limits
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] >= TARGET_MIN && m_tdata[8:0] <= TARGET_MAX))
		else $error("rudder target out of range");

	// direction up only while the motor is driven
	a_up_needs_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17]) |-> (m_tdata[16:9] != 8'd0))
		else $error("drive up with zero speed");

	// speed is one of the configured values or stopped
	a_speed_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:9] == 8'd0 || m_tdata[16:9] == cfg.drive_full ||
			m_tdata[16:9] == cfg.drive_slow))
		else $error("drive speed not from configuration");

	// a full stage one moves forward whenever the output side is free
	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv2) |=> valid_s2)
		else $error("stage one beat lost");

endmodule
